[rtl/core/nps_pkg.sv]
package nps_pkg;

	// table geometry
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;

	// coordinate and result widths
	localparam int LAT_W   = 24;
	localparam int LON_W   = 25;
	localparam int ENTRY_W = LAT_W + LON_W;
	localparam int DLAT_W  = LAT_W + 1;
	localparam int DLON_W  = LON_W + 1;
	localparam int SQ_W    = 50;
	localparam int DIST_W  = SQ_W + 1;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int STEP_W  = $clog2(ROOT_W);

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// query sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ROOT,
		ST_DONE
	} st_t;

endpackage

[rtl/core/nps_ram.sv]
module nps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/nps_sqrt.sv]
module nps_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nps_pkg::SQ_W-1:0]    radicand,
	output logic                        done,
	output logic [nps_pkg::ROOT_W-1:0]  root
);

	logic [nps_pkg::SQ_W-1:0]   rad_q;
	logic [nps_pkg::REM_W-1:0]  rem_q;
	logic [nps_pkg::ROOT_W-1:0] root_q;
	logic [nps_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [nps_pkg::REM_W+1:0] rem_sh;
	logic [nps_pkg::REM_W+1:0] trial;
	logic [nps_pkg::REM_W+1:0] rem_sub;
	logic                      ge;

	// one root bit per cycle: bring down two radicand bits, try 4*root+1
	assign rem_sh  = {rem_q, rad_q[nps_pkg::SQ_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign ge      = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= nps_pkg::STEP_W'(nps_pkg::ROOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[nps_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[nps_pkg::REM_W-1:0] : rem_sh[nps_pkg::REM_W-1:0];
			root_q <= {root_q[nps_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/core/nearest_point_search.sv]
// load word: written to the point table at once when accepted
// query word: result word after scan, drain and root, once the output is free (count clamped
//   to 1024): the scan reads one table entry per cycle, a 4-stage distance pipe, a 25-step root
// input ready again in the cycle the result word appears; one word in flight at a time
// empty table: no scan and no root, the result word is loaded straight from the done state
// reset: point_count goes to 0, sequencer idle, no result pending; table undefined
module nearest_point_search (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [nps_pkg::CNT_W-1:0]        cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [nps_pkg::IDX_W-1:0]        point_index,
	input  logic signed [nps_pkg::LAT_W-1:0] lat_value,
	input  logic signed [nps_pkg::LON_W-1:0] lon_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [nps_pkg::IDX_W-1:0]        closest_index,
	output logic [nps_pkg::SQ_W-1:0]         min_sq_distance,
	output logic [nps_pkg::ROOT_W-1:0]       min_distance
);

	nps_pkg::st_t st_q, st_d;

	logic [nps_pkg::CNT_W-1:0] point_count_q;
	logic [nps_pkg::CNT_W-1:0] cnt_lim;
	logic [nps_pkg::CNT_W-1:0] cnt_m1;
	logic                      cnt_empty;

	logic signed [nps_pkg::LAT_W-1:0] qlat_q;
	logic signed [nps_pkg::LON_W-1:0] qlon_q;
	logic [nps_pkg::IDX_W-1:0]        n_last_q;
	logic [nps_pkg::IDX_W-1:0]        scan_idx_q;
	logic                             scan_last;

	logic q_acc;
	logic ram_we;
	logic rd_en;
	logic pipe_empty;
	logic sqrt_start;
	logic sqrt_done;
	logic out_free;
	logic out_load;

	logic [nps_pkg::ENTRY_W-1:0] rdata;
	logic [nps_pkg::ROOT_W-1:0]  root;

	// distance pipe
	logic                              v_s1, v_s2, v_s3, v_s4;
	logic [nps_pkg::IDX_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [nps_pkg::DLAT_W-1:0] dlat;
	logic signed [nps_pkg::DLON_W-1:0] dlon;
	logic [nps_pkg::DLAT_W-1:0]        alat_s2;
	logic [nps_pkg::DLON_W-1:0]        alon_s2;
	logic [2*nps_pkg::DLAT_W-1:0]      sqlat_s3;
	logic [2*nps_pkg::DLON_W-1:0]      sqlon_s3;
	logic [nps_pkg::DIST_W-1:0]        dist_s4;

	// running minimum
	logic                       found_q;
	logic [nps_pkg::DIST_W-1:0] best_q;
	logic [nps_pkg::IDX_W-1:0]  best_idx_q;
	logic [nps_pkg::SQ_W-1:0]   best_sat;

	// output register
	logic                       out_valid_q;
	logic                       out_found_q;
	logic [nps_pkg::IDX_W-1:0]  out_idx_q;
	logic [nps_pkg::SQ_W-1:0]   out_sq_q;
	logic [nps_pkg::ROOT_W-1:0] out_root_q;

	// point count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_wr_en) begin
			point_count_q <= cfg_wr_data;
		end
	end

	// clamp the count to the table size
	assign cnt_lim   = (point_count_q > nps_pkg::CNT_W'(nps_pkg::MAX_POINTS))
	                 ? nps_pkg::CNT_W'(nps_pkg::MAX_POINTS) : point_count_q;
	assign cnt_empty = cnt_lim == '0;
	assign cnt_m1    = cnt_lim - 1'b1;

	assign q_acc      = in_valid && in_ready && (req_type == nps_pkg::REQ_QUERY);
	assign scan_last  = scan_idx_q == n_last_q;
	assign pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign out_free   = !out_valid_q || out_ready;

	// sequencer next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			nps_pkg::ST_IDLE: begin
				if (q_acc) begin
					st_d = cnt_empty ? nps_pkg::ST_DONE : nps_pkg::ST_SCAN;
				end
			end
			nps_pkg::ST_SCAN: begin
				if (scan_last) begin
					st_d = nps_pkg::ST_DRAIN;
				end
			end
			nps_pkg::ST_DRAIN: begin
				if (pipe_empty) begin
					st_d = nps_pkg::ST_ROOT;
				end
			end
			nps_pkg::ST_ROOT: begin
				if (sqrt_done) begin
					st_d = nps_pkg::ST_DONE;
				end
			end
			nps_pkg::ST_DONE: begin
				if (out_free) begin
					st_d = nps_pkg::ST_IDLE;
				end
			end
			default: st_d = nps_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = st_q == nps_pkg::ST_IDLE;
		ram_we     = in_ready && in_valid && (req_type == nps_pkg::REQ_LOAD);
		rd_en      = st_q == nps_pkg::ST_SCAN;
		sqrt_start = (st_q == nps_pkg::ST_DRAIN) && pipe_empty;
		out_load   = (st_q == nps_pkg::ST_DONE) && out_free;
	end

	// state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= nps_pkg::ST_IDLE;
			scan_idx_q <= '0;
			n_last_q   <= '0;
		end else begin
			st_q <= st_d;
			if (q_acc) begin
				scan_idx_q <= '0;
				n_last_q   <= cnt_m1[nps_pkg::IDX_W-1:0];
			end else if (rd_en && !scan_last) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// query coordinate
	always_ff @(posedge clk) begin
		if (q_acc) begin
			qlat_q <= lat_value;
			qlon_q <= lon_value;
		end
	end

	// point table: latitude in the upper bits, longitude in the lower
	nps_ram #(
		.WIDTH(nps_pkg::ENTRY_W),
		.DEPTH(nps_pkg::MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(point_index),
		.wdata({lat_value, lon_value}),
		.re   (rd_en),
		.raddr(scan_idx_q),
		.rdata(rdata)
	);

	// differences, query minus stored point
	assign dlat = nps_pkg::DLAT_W'(qlat_q)
	            - nps_pkg::DLAT_W'($signed(rdata[nps_pkg::ENTRY_W-1:nps_pkg::LON_W]));
	assign dlon = nps_pkg::DLON_W'(qlon_q)
	            - nps_pkg::DLON_W'($signed(rdata[nps_pkg::LON_W-1:0]));

	// pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// magnitude, square, sum
	always_ff @(posedge clk) begin
		idx_s1   <= scan_idx_q;
		idx_s2   <= idx_s1;
		idx_s3   <= idx_s2;
		idx_s4   <= idx_s3;
		alat_s2  <= dlat[nps_pkg::DLAT_W-1] ? (~dlat + 1'b1) : dlat;
		alon_s2  <= dlon[nps_pkg::DLON_W-1] ? (~dlon + 1'b1) : dlon;
		sqlat_s3 <= {{nps_pkg::DLAT_W{1'b0}}, alat_s2} * {{nps_pkg::DLAT_W{1'b0}}, alat_s2};
		sqlon_s3 <= {{nps_pkg::DLON_W{1'b0}}, alon_s2} * {{nps_pkg::DLON_W{1'b0}}, alon_s2};
		dist_s4  <= nps_pkg::DIST_W'(sqlat_s3[2*nps_pkg::DLAT_W-2:0])
		          + sqlon_s3[nps_pkg::DIST_W-1:0];
	end

	// running minimum, strict compare keeps the earlier index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (q_acc) begin
			found_q <= 1'b0;
		end else if (v_s4) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_acc) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (v_s4 && (!found_q || dist_s4 < best_q)) begin
			best_q     <= dist_s4;
			best_idx_q <= idx_s4;
		end
	end

	// saturate to the output width
	assign best_sat = best_q[nps_pkg::SQ_W] ? {nps_pkg::SQ_W{1'b1}}
	                                        : best_q[nps_pkg::SQ_W-1:0];

	nps_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(best_sat),
		.done    (sqrt_done),
		.root    (root)
	);

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_q;
			out_idx_q   <= found_q ? best_idx_q : '0;
			out_sq_q    <= found_q ? best_sat : '0;
			out_root_q  <= found_q ? root : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = out_found_q;
	assign closest_index   = out_idx_q;
	assign min_sq_distance = out_sq_q;
	assign min_distance    = out_root_q;

	// a query closes the input until its result word is loaded into the output register
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> !in_ready)
		else $error("input taken while a query is in progress");

	// distance results reach the minimum only during a scan or the drain after it
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (st_q == nps_pkg::ST_SCAN || st_q == nps_pkg::ST_DRAIN))
		else $error("distance pipe active outside a query scan");

	// empty result carries zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (closest_index == '0 && min_sq_distance == '0
			&& min_distance == '0))
		else $error("empty result with nonzero fields");

	// root is the floor square root of the squared distance
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |->
			((52'(min_distance) * 52'(min_distance)) <= 52'(min_sq_distance)
			&& ((52'(min_distance) + 52'd1) * (52'(min_distance) + 52'd1))
				> 52'(min_sq_distance)))
		else $error("min_distance is not the floor root");

endmodule

[tb/sv/tb.sv]
module tb;
	import nps_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int RANDOM_WORDS    = 420;
	localparam int FILL_SLOTS      = 128;
	localparam int SETTLE_CYCLES   = 40;
	localparam int WATCHDOG_CYCLES = 6000;
	localparam int HOLD_OFF_CYCLES = 400;

	localparam logic signed [LAT_W-1:0] LAT_TOP = {1'b0, {(LAT_W-1){1'b1}}};
	localparam logic signed [LAT_W-1:0] LAT_BOT = {1'b1, {(LAT_W-1){1'b0}}};
	localparam logic signed [LON_W-1:0] LON_TOP = {1'b0, {(LON_W-1){1'b1}}};
	localparam logic signed [LON_W-1:0] LON_BOT = {1'b1, {(LON_W-1){1'b0}}};
	localparam logic [SQ_W-1:0]         SQ_CAP   = '1;
	localparam logic [ROOT_W-1:0]       ROOT_CAP = '1;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [SQ_W-1:0]   dsq;
		logic [ROOT_W-1:0] rt;
	} answer_t;

	typedef struct packed {
		logic    pinned;
		answer_t want;
	} pin_t;

	typedef enum logic [1:0] {
		ROW_COUNT,
		ROW_LOAD,
		ROW_QUERY
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] count_or_slot;
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
		logic             pinned;
		answer_t          want;
	} probe_t;

	localparam answer_t NO_POINT = '0;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]        cfg_wr_data = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic                    req_type    = REQ_LOAD;
	logic [IDX_W-1:0]        point_index = '0;
	logic signed [LAT_W-1:0] lat_value   = '0;
	logic signed [LON_W-1:0] lon_value   = '0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic                    found;
	logic [IDX_W-1:0]        closest_index;
	logic [SQ_W-1:0]         min_sq_distance;
	logic [ROOT_W-1:0]       min_distance;

	// predictor state: point table and active count as the block should hold them
	logic signed [LAT_W-1:0] lat_tab [MAX_POINTS];
	logic signed [LON_W-1:0] lon_tab [MAX_POINTS];
	logic [CNT_W-1:0]        live_count = '0;

	answer_t answers_due [$];
	pin_t    typed_answers [$];

	int faults        = 0;
	int loads_seen    = 0;
	int queries_seen  = 0;
	int results_seen  = 0;
	int count_writes  = 0;
	int top_count     = 0;
	int quiet_cycles  = 0;
	int send_idle_pct = 18;

	nearest_point_search DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.point_index     (point_index),
		.lat_value       (lat_value),
		.lon_value       (lon_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.closest_index   (closest_index),
		.min_sq_distance (min_sq_distance),
		.min_distance    (min_distance)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// floor square root, one result bit per step from the top
	function automatic logic [ROOT_W-1:0] floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r[ROOT_W-1:0];
	endfunction

	// first stored point at the smallest exact squared distance
	function automatic answer_t nearest_of(logic signed [LAT_W-1:0] qlat,
			logic signed [LON_W-1:0] qlon);
		answer_t         a;
		longint unsigned best;
		longint unsigned d;
		longint          dl;
		longint          dn;
		int              n;
		a = NO_POINT;
		best = 0;
		n = (live_count > MAX_POINTS) ? MAX_POINTS : int'(live_count);
		for (int i = 0; i < n; i++) begin
			dl = longint'(qlat) - longint'(lat_tab[i]);
			dn = longint'(qlon) - longint'(lon_tab[i]);
			d = dl * dl + dn * dn;
			if (!a.found || d < best) begin
				a.found = 1'b1;
				a.idx = IDX_W'(i);
				best = d;
			end
		end
		if (a.found) begin
			// wide distances saturate on output, the comparison above stays exact
			if (best > longint'(SQ_CAP))
				best = SQ_CAP;
			a.dsq = best[SQ_W-1:0];
			a.rt = floor_root(best);
		end
		return a;
	endfunction

	function automatic answer_t hit(int slot, logic [SQ_W-1:0] dsq, logic [ROOT_W-1:0] rt);
		answer_t a;
		a.found = 1'b1;
		a.idx = IDX_W'(slot);
		a.dsq = dsq;
		a.rt = rt;
		return a;
	endfunction

	function automatic probe_t count_row(int n);
		probe_t p;
		p = '0;
		p.kind = ROW_COUNT;
		p.count_or_slot = CNT_W'(n);
		return p;
	endfunction

	function automatic probe_t load_row(int slot, logic signed [LAT_W-1:0] lat,
			logic signed [LON_W-1:0] lon);
		probe_t p;
		p = '0;
		p.kind = ROW_LOAD;
		p.count_or_slot = CNT_W'(slot);
		p.lat = lat;
		p.lon = lon;
		return p;
	endfunction

	function automatic probe_t ask_row(logic signed [LAT_W-1:0] lat,
			logic signed [LON_W-1:0] lon);
		probe_t p;
		p = '0;
		p.kind = ROW_QUERY;
		p.lat = lat;
		p.lon = lon;
		return p;
	endfunction

	function automatic probe_t ask_known(logic signed [LAT_W-1:0] lat,
			logic signed [LON_W-1:0] lon, answer_t want);
		probe_t p;
		p = ask_row(lat, lon);
		p.pinned = 1'b1;
		p.want = want;
		return p;
	endfunction

	// coordinate mix: width extremes, range edges, any bit pattern, in range
	function automatic logic signed [LON_W-1:0] rand_coord(bit is_lon);
		int                      reach;
		logic signed [LON_W-1:0] v;
		reach = is_lon ? 11796480 : 5898240;
		case ($urandom_range(0, 11))
			0: v = is_lon ? LON_TOP : LON_W'(LAT_TOP);
			1: v = is_lon ? LON_BOT : LON_W'(LAT_BOT);
			2: v = LON_W'(reach);
			3: v = LON_W'(-reach);
			4: v = '0;
			5, 6: v = LON_W'($urandom);
			default: v = LON_W'(int'($urandom_range(0, 2 * reach)) - reach);
		endcase
		return v;
	endfunction

	function automatic int pick_slot(int span);
		return (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, FILL_SLOTS - 1);
	endfunction

	task automatic log_fault(string why, answer_t want, answer_t got);
		faults++;
		if (faults <= 10) begin
			$display("%s at %0t: expected found=%0d idx=%0d dsq=%0d root=%0d", why, $realtime,
				want.found, want.idx, want.dsq, want.rt);
			$display("    got found=%0d idx=%0d dsq=%0d root=%0d",
				got.found, got.idx, got.dsq, got.rt);
		end
	endtask

	// offer one word and hold it until the block takes it
	task automatic offer(logic kind, logic [IDX_W-1:0] slot, logic signed [LAT_W-1:0] lat,
			logic signed [LON_W-1:0] lon, logic pinned, answer_t want);
		pin_t pin;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pin.pinned = pinned;
		pin.want = want;
		if (kind == REQ_QUERY)
			typed_answers.push_back(pin);
		in_valid <= 1'b1;
		req_type <= kind;
		point_index <= slot;
		lat_value <= lat;
		lon_value <= lon;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drain every pending result, then give a trailing load time to land
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(int n);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CNT_W'(n);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_word(int span);
		int                      s;
		int                      o;
		logic signed [LAT_W-1:0] la;
		logic signed [LON_W-1:0] lo;
		s = pick_slot(span);
		o = pick_slot(span);
		if ($urandom_range(0, 99) < 35) begin
			// load: mostly into the active part, now and then a copy of a point for ties
			if ($urandom_range(0, 4) == 0)
				s = $urandom_range(0, MAX_POINTS - 1);
			la = LAT_W'(rand_coord(1'b0));
			lo = rand_coord(1'b1);
			if ($urandom_range(0, 3) == 0) begin
				la = lat_tab[o];
				lo = lon_tab[o];
			end
			offer(REQ_LOAD, IDX_W'(s), la, lo, 1'b0, NO_POINT);
		end else begin
			// query: right on a stored point, close to one, or anywhere
			case ($urandom_range(0, 3))
				0: begin
					la = lat_tab[s];
					lo = lon_tab[s];
				end
				1: begin
					la = LAT_W'(lat_tab[s] + (int'($urandom_range(0, 64)) - 32));
					lo = LON_W'(lon_tab[s] + (int'($urandom_range(0, 8192)) - 4096));
				end
				default: begin
					la = LAT_W'(rand_coord(1'b0));
					lo = rand_coord(1'b1);
				end
			endcase
			offer(REQ_QUERY, IDX_W'($urandom), la, lo, 1'b0, NO_POINT);
		end
	endtask

	// result side: random stalls, a clean stretch, then a long hold-off
	initial begin : drain_side
		wait (arst_n);
		forever begin
			repeat (2000) begin
				out_ready <= ($urandom_range(0, 99) >= 18);
				@(posedge clk);
			end
			out_ready <= 1'b1;
			repeat (1500) @(posedge clk);
			out_ready <= 1'b0;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
		end
	end

	// monitor: track writes, predict each query, check each result word
	always @(posedge clk) begin : watch
		pin_t    pin;
		answer_t got;
		answer_t want;
		if (cfg_wr_en) begin
			live_count = cfg_wr_data;
			count_writes++;
			if (int'(cfg_wr_data) > top_count)
				top_count = int'(cfg_wr_data);
		end
		if (in_valid && in_ready) begin
			if (req_type == REQ_LOAD) begin
				lat_tab[point_index] = lat_value;
				lon_tab[point_index] = lon_value;
				loads_seen++;
			end else begin
				pin = (typed_answers.size() != 0) ? typed_answers.pop_front() : '0;
				answers_due.push_back(pin.pinned ? pin.want : nearest_of(lat_value, lon_value));
				queries_seen++;
			end
		end
		if (out_valid && out_ready) begin
			results_seen++;
			got.found = found;
			got.idx = closest_index;
			got.dsq = min_sq_distance;
			got.rt = min_distance;
			if (answers_due.size() == 0) begin
				log_fault("result word with nothing pending", NO_POINT, got);
			end else begin
				want = answers_due.pop_front();
				if (got.found !== want.found || got.idx !== want.idx ||
						got.dsq !== want.dsq || got.rt !== want.rt)
					log_fault("result mismatch", want, got);
			end
		end
	end

	// watchdog on cycles without any accepted word or count write
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("no progress for %0d cycles, %0d results still pending",
				quiet_cycles, answers_due.size());
			$display("** nearest_point_search: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		probe_t plan [$];
		int     cnt;
		int     span;
		int     batch;
		int     pick;
		int     big_phases;
		int     phase_no;
		int     random_words;
		big_phases = 0;
		phase_no = 0;
		random_words = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, exact hits at the extremes, ties, saturation
		plan.push_back(ask_known(1000, -1000, NO_POINT));
		plan.push_back(load_row(0, 0, 0));
		plan.push_back(load_row(1, LAT_BOT, LON_BOT));
		plan.push_back(load_row(2, LAT_TOP, LON_TOP));
		plan.push_back(load_row(3, 0, 0));
		plan.push_back(load_row(MAX_POINTS - 1, 5898240, -11796480));
		plan.push_back(count_row(4));
		plan.push_back(ask_known(0, 0, hit(0, '0, '0)));
		plan.push_back(ask_known(LAT_TOP, LON_TOP, hit(2, '0, '0)));
		plan.push_back(ask_known(LAT_BOT, LON_BOT, hit(1, '0, '0)));
		plan.push_back(ask_row(65536, 65536));
		plan.push_back(ask_row(5898240, -11796480));
		plan.push_back(count_row(0));
		plan.push_back(ask_known(LAT_TOP, LON_TOP, NO_POINT));
		plan.push_back(load_row(0, LAT_BOT, LON_BOT));
		plan.push_back(count_row(1));
		plan.push_back(ask_known(LAT_TOP, LON_TOP, hit(0, SQ_CAP, ROOT_CAP)));
		plan.push_back(load_row(1, LAT_BOT, LON_BOT + 1));
		plan.push_back(count_row(2));
		plan.push_back(ask_row(LAT_TOP, LON_TOP));
		plan.push_back(ask_row(-5898240, 11796480));
		plan.push_back(ask_row(3, -4));
		foreach (plan[k]) begin
			case (plan[k].kind)
				ROW_COUNT: set_count(plan[k].count_or_slot);
				ROW_LOAD: offer(REQ_LOAD, plan[k].count_or_slot[IDX_W-1:0], plan[k].lat,
					plan[k].lon, 1'b0, NO_POINT);
				default: offer(REQ_QUERY, IDX_W'($urandom), plan[k].lat, plan[k].lon,
					plan[k].pinned, plan[k].want);
			endcase
		end

		// fill the low part of the table, first half back to back
		for (int s = 0; s < FILL_SLOTS; s++) begin
			send_idle_pct = (s < FILL_SLOTS / 2) ? 0 : 18;
			offer(REQ_LOAD, IDX_W'(s), LAT_W'(rand_coord(1'b0)), rand_coord(1'b1), 1'b0,
				NO_POINT);
		end

		// long scans over every filled slot
		set_count(FILL_SLOTS);
		offer(REQ_QUERY, '1, lat_tab[FILL_SLOTS - 1], lon_tab[FILL_SLOTS - 1], 1'b0, NO_POINT);
		repeat (2) random_word(FILL_SLOTS);

		// random phases, mostly short scans
		while (random_words < RANDOM_WORDS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				cnt = 0;
			end else if (pick == 1 && big_phases < 2) begin
				cnt = FILL_SLOTS;
				big_phases++;
			end else if (pick == 2) begin
				cnt = 1;
			end else begin
				cnt = $urandom_range(2, 48);
			end
			set_count(cnt);
			span = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
			batch = (span > 64) ? 6 : $urandom_range(12, 40);
			send_idle_pct = (phase_no % 6 == 3) ? 0 : 18;
			repeat (batch) begin
				random_word(span);
				random_words++;
			end
			phase_no++;
		end

		settle();

		$display("covered %0d load and %0d query words, %0d result words checked, %0d faults",
			loads_seen, queries_seen, results_seen, faults);
		$display("point_count written %0d times, up to %0d, with empty tables and long scans",
			count_writes, top_count);
		if (faults == 0 && answers_due.size() == 0)
			$display("** nearest_point_search: PASSED **");
		else
			$display("** nearest_point_search: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/core/nps_pkg.sv
rtl/core/nps_ram.sv
rtl/core/nps_sqrt.sv
rtl/core/nearest_point_search.sv
tb/sv/tb.sv
